// ===== rtl/core/mcl_pkg.sv =====
// Shared types and constants for the mini C lexer.
// Holds token kind codes, keyword spellings and the result record type.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcl_pkg;

    // Token length saturates at this value; the truncated flag is raised for longer words.
    localparam logic [7:0] MAX_TOKEN_LENGTH = 8'd128;

    // Token kind codes as they appear on the token_kind port.
    localparam logic [4:0] KIND_INT     = 5'd0;
    localparam logic [4:0] KIND_RETURN  = 5'd1;
    localparam logic [4:0] KIND_SEMI    = 5'd2;
    localparam logic [4:0] KIND_FLOAT   = 5'd3;
    localparam logic [4:0] KIND_IDENT   = 5'd4;
    localparam logic [4:0] KIND_NUMBER  = 5'd5;
    localparam logic [4:0] KIND_LPAREN  = 5'd6;
    localparam logic [4:0] KIND_RPAREN  = 5'd7;
    localparam logic [4:0] KIND_LCURLY  = 5'd8;
    localparam logic [4:0] KIND_RCURLY  = 5'd9;
    localparam logic [4:0] KIND_LSQUARE = 5'd10;
    localparam logic [4:0] KIND_RSQUARE = 5'd11;
    localparam logic [4:0] KIND_FOR     = 5'd12;
    localparam logic [4:0] KIND_WHILE   = 5'd13;
    localparam logic [4:0] KIND_EQUAL   = 5'd14;
    localparam logic [4:0] KIND_EOF     = 5'd15;
    localparam logic [4:0] KIND_UNKNOWN = 5'd16;

    // Keyword spellings as they sit in the keyword window, newest byte lowest.
    localparam logic [47:0] KW_RETURN = 48'h72657475726E;
    localparam logic [47:0] KW_INT    = 48'h000000696E74;
    localparam logic [47:0] KW_FLOAT  = 48'h00666C6F6174;
    localparam logic [47:0] KW_FOR    = 48'h000000666F72;
    localparam logic [47:0] KW_WHILE  = 48'h007768696C65;

    // One token as delivered on the output channel.
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [7:0]  length;
        logic        truncated;
        logic        last;
    } token_t;

    // Tokens produced by one accepted input item, packed from the front.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcl_scan.sv =====
// Scanner core of the mini C lexer: character classes, token state and keyword match.
// Produces up to two tokens for each accepted item; depends on mcl_pkg.
`default_nettype none

module mcl_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              action,
    input  wire logic [7:0]        character,
    output mcl_pkg::scan_out_t     result
);
    import mcl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] pos_reg, pos_next;
    logic [47:0] window_reg, window_next;
    logic        ovf_reg, ovf_next;

    logic        is_letter, is_digit, is_space;
    logic        extend, pending, start_tok;
    logic [7:0]  base_len;
    logic [47:0] base_window;
    logic        base_ovf;
    logic [4:0]  word_kind, single_kind;
    token_t      flush_tok, tail_tok;
    logic        flush_vld, tail_vld;

    // Character classes, ASCII only.
    always_comb
    begin
        is_letter = (character inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
        is_digit  = (character inside {[8'h30:8'h39]});
        is_space  = (character inside {[8'h09:8'h0D], 8'h20});
    end

    // Kind of a single-character token.
    always_comb
    begin
        case (character)
            8'h3B:   single_kind = KIND_SEMI;
            8'h28:   single_kind = KIND_LPAREN;
            8'h29:   single_kind = KIND_RPAREN;
            8'h7B:   single_kind = KIND_LCURLY;
            8'h7D:   single_kind = KIND_RCURLY;
            8'h5B:   single_kind = KIND_LSQUARE;
            8'h5D:   single_kind = KIND_RSQUARE;
            8'h3D:   single_kind = KIND_EQUAL;
            default: single_kind = KIND_UNKNOWN;
        endcase
    end

    // Kind of the pending word; a truncated word is never a keyword.
    always_comb
    begin
        word_kind = KIND_IDENT;
        if (mode_reg == MODE_NUMBER)
        begin
            word_kind = KIND_NUMBER;
        end
        else if (!ovf_reg)
        begin
            if (len_reg == 8'd6 && window_reg == KW_RETURN)
            begin
                word_kind = KIND_RETURN;
            end
            else if (len_reg == 8'd3 && window_reg == KW_INT)
            begin
                word_kind = KIND_INT;
            end
            else if (len_reg == 8'd5 && window_reg == KW_FLOAT)
            begin
                word_kind = KIND_FLOAT;
            end
            else if (len_reg == 8'd3 && window_reg == KW_FOR)
            begin
                word_kind = KIND_FOR;
            end
            else if (len_reg == 8'd5 && window_reg == KW_WHILE)
            begin
                word_kind = KIND_WHILE;
            end
        end
    end

    // Decide whether the byte extends the pending word, ends it, or starts a new one.
    always_comb
    begin
        pending   = (mode_reg != MODE_IDLE);
        extend    = !action && (((mode_reg == MODE_IDENT) && (is_letter || is_digit))
                    || ((mode_reg == MODE_NUMBER) && is_digit));
        start_tok = !action && !extend && (is_letter || is_digit);

        flush_vld = pending && !extend;
        tail_vld  = action || (!extend && !is_space && !is_letter && !is_digit);

        flush_tok.kind      = word_kind;
        flush_tok.start     = start_reg;
        flush_tok.length    = len_reg;
        flush_tok.truncated = ovf_reg;
        flush_tok.last      = !tail_vld;

        tail_tok.kind      = action ? KIND_EOF : single_kind;
        tail_tok.start     = pos_reg;
        tail_tok.length    = action ? 8'd0 : 8'd1;
        tail_tok.truncated = 1'b0;
        tail_tok.last      = 1'b1;
    end

    // Pack the produced tokens towards the first slot.
    always_comb
    begin
        result.count  = {1'b0, flush_vld} + {1'b0, tail_vld};
        result.first  = flush_vld ? flush_tok : tail_tok;
        result.second = tail_tok;
    end

    // Next scanner state: extend from the pending word or from an empty one.
    always_comb
    begin
        base_len    = extend ? len_reg : 8'd0;
        base_window = extend ? window_reg : 48'd0;
        base_ovf    = extend ? ovf_reg : 1'b0;

        mode_next   = mode_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        window_next = window_reg;
        ovf_next    = ovf_reg;
        pos_next    = action ? 32'd0 : pos_reg + 32'd1;

        if (extend || start_tok)
        begin
            window_next = (base_len < 8'd6) ? {base_window[39:0], character} : base_window;
            len_next    = (base_len < MAX_TOKEN_LENGTH) ? base_len + 8'd1 : base_len;
            ovf_next    = base_ovf || (base_len >= MAX_TOKEN_LENGTH);
            if (start_tok)
            begin
                mode_next  = is_letter ? MODE_IDENT : MODE_NUMBER;
                start_next = pos_reg;
            end
        end
        else
        begin
            mode_next   = MODE_IDLE;
            len_next    = 8'd0;
            window_next = 48'd0;
            ovf_next    = 1'b0;
        end
    end

    // Scanner state registers, updated on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= 8'd0;
            start_reg  <= 32'd0;
            pos_reg    <= 32'd0;
            window_reg <= 48'd0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            window_reg <= window_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcl_token_queue.sv =====
// Result queue of the mini C lexer: takes up to two tokens a cycle, gives one.
// Four entries held in registers; depends on mcl_pkg.
`default_nettype none

module mcl_token_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  mcl_pkg::scan_out_t      push_data,
    input  wire logic               pop,
    output mcl_pkg::token_t         head,
    output logic                    not_empty,
    output logic                    near_full
);
    import mcl_pkg::*;

    token_t     mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [2:0] push_count;

    // Status and head of queue.
    always_comb
    begin
        not_empty = (count_reg != 3'd0);
        near_full = (count_reg > 3'd2);
        head      = mem[rd_ptr_reg];
    end

    // Pointer and fill arithmetic.
    always_comb
    begin
        push_count  = push ? {1'b0, push_data.count} : 3'd0;
        wr_ptr_next = wr_ptr_reg + push_count[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + push_count - {2'b00, pop};
    end

    // Entry storage; the second token goes to the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push && push_data.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data.first;
        end
        if (push && push_data.count == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push_data.second;
        end
    end

    // Queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mini_c_lexer.sv =====
// Top level of the mini C lexer: byte input channel, token output channel.
// Instantiates mcl_scan and mcl_token_queue; depends on mcl_pkg.
//
// Usage:
//   The input channel carries one item per transfer: action 0 with a source
//   byte in character, or action 1 for end of input. A transfer takes place
//   when in_valid is high and in_stall is low at a rising edge of clk.
//   The output channel carries one token per transfer on the same rule with
//   out_valid and out_stall; last_of_run marks the final token of an item.
//   An item yields zero, one or two tokens.
//   The tokens of an item enter the token queue at its transfer and are shown
//   from its head. Throughput: one item per cycle while each item yields at
//   most one token and out_stall stays low. The rate is set by the four-entry
//   token queue, which drains one token a cycle while out_stall is low.
//   in_stall rises while the queue holds more than two tokens, so it is high
//   whenever the receiver stalls long enough to fill the queue; tokens are
//   held unchanged while out_stall is high.
//   Reset (rst_n low, asynchronous) empties the queue, clears any pending
//   token and sets the byte offset to zero.
`default_nettype none

module mini_c_lexer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  character,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       token_kind,
    output logic [31:0]      start_offset,
    output logic [7:0]       token_length,
    output logic             truncated,
    output logic             last_of_run
);
    import mcl_pkg::*;

    logic      in_xfer;
    logic      out_xfer;
    logic      near_full;
    scan_out_t scan_result;
    token_t    head;

    // Handshake decode.
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_stall = near_full;

    // Scanner: classifies each byte and emits the tokens it closes.
    mcl_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .action    (action),
        .character (character),
        .result    (scan_result)
    );

    // Token queue between the scanner and the output channel.
    mcl_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (scan_result),
        .pop       (out_xfer),
        .head      (head),
        .not_empty (out_valid),
        .near_full (near_full)
    );

    // Output fields come straight from the head of the queue.
    assign token_kind   = head.kind;
    assign start_offset = head.start;
    assign token_length = head.length;
    assign truncated    = head.truncated;
    assign last_of_run  = head.last;

endmodule

`default_nettype wire

// ===== dv/tb_mini_c_lexer.sv =====
// Self-checking testbench for mini_c_lexer: drives source bytes and end-of-input items,
// predicts every token in the bench and compares each token transfer field by field.
// Depends on mcl_pkg and mini_c_lexer.
`default_nettype none

module tb_mini_c_lexer;

    timeunit 1ns;
    timeprecision 1ps;

    import mcl_pkg::*;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER} scan_mode_t;

    // One row of the directed sequence; typed rows carry their own expected token.
    typedef struct {
        logic        act;
        logic [7:0]  ch;
        bit          typed;
        logic [4:0]  kind;
        logic [31:0] start;
        logic [7:0]  len;
    } lex_row_t;

    localparam int N_DIRECTED = 26;
    localparam int N_RANDOM_PER_PHASE = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [7:0]  character = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [7:0]  token_length;
    logic        truncated;
    logic        last_of_run;

    // Shadow state of the scanner.
    scan_mode_t  scan_mode;
    logic [7:0]  word_len;
    logic [31:0] word_start;
    logic [31:0] byte_pos;
    logic [47:0] word_window;
    logic        word_overflow;

    token_t      item_tokens[$];
    token_t      awaited_tokens[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    string keywords [5] = '{"return", "int", "float", "for", "while"};
    string near_words [14] = '{"retur", "returns", "in", "intx", "Int", "flo", "floats",
                               "fo", "form", "whil", "whiles", "_int", "int_", "for1"};

    // Directed sequence: punctuation, extreme bytes, a keyword, an identifier with a
    // leading underscore, a number closed by punctuation and a word closed by end of input.
    lex_row_t directed_rows [N_DIRECTED] = '{
        '{1'b1, 8'h00, 1'b1, KIND_EOF,     32'd0,  8'd0},
        '{1'b0, ";",   1'b1, KIND_SEMI,    32'd0,  8'd1},
        '{1'b0, "(",   1'b1, KIND_LPAREN,  32'd1,  8'd1},
        '{1'b0, ")",   1'b1, KIND_RPAREN,  32'd2,  8'd1},
        '{1'b0, "{",   1'b1, KIND_LCURLY,  32'd3,  8'd1},
        '{1'b0, "}",   1'b1, KIND_RCURLY,  32'd4,  8'd1},
        '{1'b0, "[",   1'b1, KIND_LSQUARE, 32'd5,  8'd1},
        '{1'b0, "]",   1'b1, KIND_RSQUARE, 32'd6,  8'd1},
        '{1'b0, "=",   1'b1, KIND_EQUAL,   32'd7,  8'd1},
        '{1'b0, 8'h00, 1'b1, KIND_UNKNOWN, 32'd8,  8'd1},
        '{1'b0, 8'hFF, 1'b1, KIND_UNKNOWN, 32'd9,  8'd1},
        '{1'b0, 8'h80, 1'b1, KIND_UNKNOWN, 32'd10, 8'd1},
        '{1'b0, "f",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "o",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "r",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, 8'h09, 1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "_",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "a",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "9",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, 8'h20, 1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "4",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "2",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "(",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, "w",   1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b1, 8'hA5, 1'b0, KIND_IDENT,   32'd0,  8'd0},
        '{1'b0, 8'h0D, 1'b0, KIND_IDENT,   32'd0,  8'd0}
    };

    mini_c_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .character    (character),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .truncated    (truncated),
        .last_of_run  (last_of_run)
    );

    // Clock generation.
    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void emit_token(logic [4:0] kind, logic [31:0] start,
                                       logic [7:0] len, logic trunc);
        item_tokens.push_back(token_t'{kind, start, len, trunc, 1'b0});
    endfunction

    // Keywords are matched on the first six bytes and the length; an overlong word never is one.
    function automatic logic [4:0] word_kind();
        if (word_overflow)
            return KIND_IDENT;
        if (word_len == 8'd6 && word_window == KW_RETURN)
            return KIND_RETURN;
        if (word_len == 8'd3 && word_window == KW_INT)
            return KIND_INT;
        if (word_len == 8'd5 && word_window == KW_FLOAT)
            return KIND_FLOAT;
        if (word_len == 8'd3 && word_window == KW_FOR)
            return KIND_FOR;
        if (word_len == 8'd5 && word_window == KW_WHILE)
            return KIND_WHILE;
        return KIND_IDENT;
    endfunction

    function automatic void close_word();
        if (scan_mode == SCAN_IDENT)
            emit_token(word_kind(), word_start, word_len, word_overflow);
        else if (scan_mode == SCAN_NUMBER)
            emit_token(KIND_NUMBER, word_start, word_len, word_overflow);
        scan_mode = SCAN_IDLE;
        word_len = 8'd0;
        word_overflow = 1'b0;
        word_window = 48'd0;
    endfunction

    function automatic void grow_word(logic [7:0] c);
        if (word_len < 8'd6)
            word_window = {word_window[39:0], c};
        if (word_len < MAX_TOKEN_LENGTH)
            word_len = word_len + 8'd1;
        else
            word_overflow = 1'b1;
    endfunction

    function automatic logic [4:0] punct_kind(logic [7:0] c);
        case (c)
            ";": return KIND_SEMI;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            "{": return KIND_LCURLY;
            "}": return KIND_RCURLY;
            "[": return KIND_LSQUARE;
            "]": return KIND_RSQUARE;
            "=": return KIND_EQUAL;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    // Works out the tokens that one input item causes and advances the shadow state.
    function automatic void lex_item(logic act, logic [7:0] c);
        item_tokens.delete();
        if (act)
        begin
            close_word();
            emit_token(KIND_EOF, byte_pos, 8'd0, 1'b0);
            byte_pos = 32'd0;
        end
        else
        begin
            if (scan_mode == SCAN_IDENT && (is_letter(c) || is_digit(c)))
                grow_word(c);
            else if (scan_mode == SCAN_NUMBER && is_digit(c))
                grow_word(c);
            else
            begin
                close_word();
                if (is_letter(c) || is_digit(c))
                begin
                    scan_mode = is_letter(c) ? SCAN_IDENT : SCAN_NUMBER;
                    word_start = byte_pos;
                    grow_word(c);
                end
                else if (!is_space(c))
                    emit_token(punct_kind(c), byte_pos, 8'd1, 1'b0);
            end
            byte_pos = byte_pos + 32'd1;
        end
        if (item_tokens.size() > 0)
            item_tokens[item_tokens.size() - 1].last = 1'b1;
    endfunction

    // Offers one item, waits for its transfer and records the tokens it should cause.
    task automatic send_item(logic act, logic [7:0] c, bit typed, token_t typed_tok);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        character <= c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        lex_item(act, c);
        if (typed)
            awaited_tokens.push_back(typed_tok);
        else
            foreach (item_tokens[i])
                awaited_tokens.push_back(item_tokens[i]);
    endtask

    task automatic send_byte(logic [7:0] c);
        send_item(1'b0, c, 1'b0, '0);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] lead_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 9);
        return (r < 3) ? 8'("0" + $urandom_range(0, 9)) : lead_char();
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(9 + r);
    endfunction

    // Random source text: mostly well-formed words and punctuation, with noise bytes and
    // end-of-input items mixed in. Each phase opens with one word around the length limit.
    task automatic run_random_phase(int phase);
        int    target;
        int    r;
        int    len;
        string puncts;
        target = items_sent + N_RANDOM_PER_PHASE;
        puncts = ";(){}[]=";
        len = $urandom_range(int'(MAX_TOKEN_LENGTH) - 2, int'(MAX_TOKEN_LENGTH) + 12);
        send_byte((phase % 2 == 0) ? lead_char() : 8'("0" + $urandom_range(0, 9)));
        for (int i = 1; i < len; i++)
            send_byte((phase % 2 == 0) ? word_char() : 8'("0" + $urandom_range(0, 9)));
        send_byte(space_char());
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                send_text(keywords[$urandom_range(0, 4)]);
            else if (r < 20)
                send_text(near_words[$urandom_range(0, 13)]);
            else if (r < 38)
            begin
                len = $urandom_range(1, 8);
                send_byte(lead_char());
                for (int i = 1; i < len; i++)
                    send_byte(word_char());
            end
            else if (r < 50)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'("0" + $urandom_range(0, 9)));
            end
            else if (r < 70)
                send_byte(puncts[$urandom_range(0, 7)]);
            else if (r < 78)
                send_byte(8'($urandom_range(0, 255)));
            else if (r < 82)
                send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_byte(space_char());
            end
            // Adjacent words run together half of the time.
            if ($urandom_range(0, 1) == 1)
                send_byte(space_char());
        end
    endtask

    // Receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every token transfer is checked against the oldest awaited token.
    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_tokens.size() == 0)
            begin
                $error("unexpected token: token_kind %0d, start_offset %0d",
                       token_kind, start_offset);
                mismatches++;
            end
            else
            begin
                want = awaited_tokens.pop_front();
                if (token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
                    mismatches++;
                end
                if (start_offset !== want.start)
                begin
                    $error("start_offset: expected %0d, actual %0d", want.start, start_offset);
                    mismatches++;
                end
                if (token_length !== want.length)
                begin
                    $error("token_length: expected %0d, actual %0d", want.length, token_length);
                    mismatches++;
                end
                if (truncated !== want.truncated)
                begin
                    $error("truncated: expected %0d, actual %0d", want.truncated, truncated);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed rows, four random phases, drain and verdict.
    initial
    begin
        int sender_idle [4];
        int receiver_stall [4];
        sender_idle = '{0, 76, 0, 34};
        receiver_stall = '{0, 0, 76, 34};
        scan_mode = SCAN_IDLE;
        word_len = 8'd0;
        word_start = 32'd0;
        byte_pos = 32'd0;
        word_window = 48'd0;
        word_overflow = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].ch, directed_rows[i].typed,
                      token_t'{directed_rows[i].kind, directed_rows[i].start,
                               directed_rows[i].len, 1'b0, 1'b1});

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = sender_idle[p];
            stall_pct = receiver_stall[p];
            run_random_phase(p);
        end

        in_valid <= 1'b0;
        while (awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
